// ===== rtl/shape_pair_contact_test_core_defines.svh =====
// assertion macros for the shape pair contact test core
`ifndef SHAPE_PAIR_CONTACT_TEST_CORE_DEFINES_SVH
`define SHAPE_PAIR_CONTACT_TEST_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc check failed");
`define SCC_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("scc latency check failed");
`else
`define SCC_ASSERT_IMP(label, ante, cons)
`define SCC_ASSERT_DLY(label, ante, n, cons)
`endif
`endif

// ===== rtl/scc_pkg.sv =====
package scc_pkg;

  localparam int NORM_FRAC  = 14;
  localparam int NORM_ONE   = 1 << NORM_FRAC;
  localparam int NORM_W     = 16;
  localparam int MAG_W      = 33;
  localparam int SQ_W       = 64;
  localparam int LEN_W      = 32;
  localparam int SQRT_STEPS = LEN_W;
  localparam int QUO_W      = NORM_FRAC + 1;
  localparam int NUM_W      = MAG_W + NORM_FRAC;

  typedef enum logic [1:0] {
    CMD_BOX_BOX       = 2'd0,
    CMD_BOX_CIRCLE    = 2'd1,
    CMD_CIRCLE_CIRCLE = 2'd2,
    CMD_NONE          = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic [30:0]        size_x_a;
    logic [30:0]        size_y_a;
    logic [30:0]        size_x_b;
    logic [30:0]        size_y_b;
    logic [30:0]        radius_a;
    logic [30:0]        radius_b;
  } request_t;

  typedef struct packed {
    logic                     hit;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [31:0]       penetration;
  } result_t;

  typedef struct packed {
    logic                     hit;
    logic                     fixed;
    logic                     halve;
    logic                     neg_a;
    logic                     neg_b;
    logic [LEN_W-1:0]         k;
    logic signed [NORM_W-1:0] fix_nx;
    logic signed [NORM_W-1:0] fix_ny;
    logic signed [31:0]       fix_pen;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    side_t            side;
  } carry_t;

endpackage

// ===== rtl/scc_front.sv =====
module scc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  scc_pkg::request_t           req,
  output logic                        out_valid,
  output logic [scc_pkg::SQ_W-1:0]    sq_sum,
  output scc_pkg::carry_t             carry
);
  import scc_pkg::*;

  // stage a: clamp, box-box overlaps, component magnitudes
  logic signed [32:0] vx, vy, lim_x, lim_y, cx, cy;
  logic [32:0]        avx, avy;
  logic signed [33:0] gx, gy;
  logic [33:0]        agx, agy;
  logic [31:0]        adx, ady;
  logic signed [33:0] ox, oy;
  logic               in_x, in_y, in_box, hit_bb, pick_x;
  carry_t             carry_a;

  always_comb begin
    vx    = {req.delta_x, 1'b0};
    vy    = {req.delta_y, 1'b0};
    lim_x = {2'b00, req.size_x_a};
    lim_y = {2'b00, req.size_y_a};
    in_x  = !(vx > lim_x) && !(vx < -lim_x);
    in_y  = !(vy > lim_y) && !(vy < -lim_y);
    cx    = (vx > lim_x) ? lim_x : ((vx < -lim_x) ? -lim_x : vx);
    cy    = (vy > lim_y) ? lim_y : ((vy < -lim_y) ? -lim_y : vy);
    avx   = vx[32] ? (~vx + 33'd1) : vx;
    avy   = vy[32] ? (~vy + 33'd1) : vy;
    in_box = in_x && in_y;
    // centre inside: push out to the face of the dominant axis
    if (in_box) begin
      if (avx > avy) begin
        cx = (vx > 0) ? lim_x : -lim_x;
      end else begin
        cy = (vy > 0) ? lim_y : -lim_y;
      end
    end
    gx  = {vx[32], vx} - {cx[32], cx};
    gy  = {vy[32], vy} - {cy[32], cy};
    agx = gx[33] ? (~gx + 34'd1) : gx;
    agy = gy[33] ? (~gy + 34'd1) : gy;
    adx = req.delta_x[31] ? (~req.delta_x + 32'd1) : req.delta_x;
    ady = req.delta_y[31] ? (~req.delta_y + 32'd1) : req.delta_y;

    // doubled overlaps
    ox = {3'b000, req.size_x_a} + {3'b000, req.size_x_b} - {1'b0, adx, 1'b0};
    oy = {3'b000, req.size_y_a} + {3'b000, req.size_y_b} - {1'b0, ady, 1'b0};
    hit_bb = !ox[33] && (ox != 0) && !oy[33] && (oy != 0);
    pick_x = ox < oy;

    carry_a = '0;
    unique case (req.command)
      CMD_BOX_BOX: begin
        carry_a.side.hit = hit_bb;
        if (pick_x) begin
          carry_a.side.fix_nx  = req.delta_x[31] ? -NORM_W'(NORM_ONE) : NORM_W'(NORM_ONE);
          carry_a.side.fix_pen = ox[32:1];
        end else begin
          carry_a.side.fix_ny  = req.delta_y[31] ? -NORM_W'(NORM_ONE) : NORM_W'(NORM_ONE);
          carry_a.side.fix_pen = oy[32:1];
        end
      end
      CMD_BOX_CIRCLE: begin
        carry_a.mag_a      = agx[MAG_W-1:0];
        carry_a.mag_b      = agy[MAG_W-1:0];
        carry_a.side.neg_a = in_box ? (!gx[33] && (gx != 0)) : gx[33];
        carry_a.side.neg_b = in_box ? (!gy[33] && (gy != 0)) : gy[33];
        carry_a.side.k     = {req.radius_b, 1'b0};
        carry_a.side.halve = 1'b1;
      end
      CMD_CIRCLE_CIRCLE: begin
        carry_a.mag_a        = {1'b0, adx};
        carry_a.mag_b        = {1'b0, ady};
        carry_a.side.neg_a   = req.delta_x[31];
        carry_a.side.neg_b   = req.delta_y[31];
        carry_a.side.k       = {1'b0, req.radius_a} + {1'b0, req.radius_b};
        carry_a.side.fix_nx  = NORM_W'(NORM_ONE);
        carry_a.side.fix_pen = {1'b0, req.radius_a};
      end
      default: begin
        carry_a = '0;
      end
    endcase
  end

  logic       a_valid, b_valid;
  logic       a_in_box, b_in_box;
  logic [1:0] a_cmd, b_cmd;
  carry_t     a_carry, b_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_in_box <= in_box;
    a_cmd    <= req.command;
    a_carry  <= carry_a;
  end

  // stage b: squares
  logic [2*MAG_W-1:0] prod_a, prod_b;
  logic [2*LEN_W-1:0] prod_k;
  logic [SQ_W-1:0]    b_sq_a, b_sq_b, b_thr;

  assign prod_a = a_carry.mag_a * a_carry.mag_a;
  assign prod_b = a_carry.mag_b * a_carry.mag_b;
  assign prod_k = a_carry.side.k * a_carry.side.k;

  always_ff @(posedge clk) begin
    b_sq_a   <= prod_a[SQ_W-1:0];
    b_sq_b   <= prod_b[SQ_W-1:0];
    b_thr    <= prod_k[SQ_W-1:0];
    b_in_box <= a_in_box;
    b_cmd    <= a_cmd;
    b_carry  <= a_carry;
  end

  // stage c: saturating sum and hit decision
  logic [SQ_W:0]   sum_full;
  logic [SQ_W-1:0] sum_sat;
  logic            in_reach;
  carry_t          carry_c;

  always_comb begin
    sum_full = {1'b0, b_sq_a} + {1'b0, b_sq_b};
    sum_sat  = sum_full[SQ_W] ? '1 : sum_full[SQ_W-1:0];
    in_reach = sum_sat <= b_thr;
    carry_c  = b_carry;
    unique case (b_cmd)
      CMD_BOX_BOX: begin
        carry_c.side.fixed = 1'b1;
      end
      CMD_BOX_CIRCLE: begin
        carry_c.side.hit = b_in_box || in_reach;
      end
      CMD_CIRCLE_CIRCLE: begin
        carry_c.side.hit   = in_reach;
        carry_c.side.fixed = sum_sat == '0;
      end
      default: begin
        carry_c.side.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sq_sum <= sum_sat;
    carry  <= carry_c;
  end

endmodule

// ===== rtl/scc_sqrt.sv =====
module scc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [scc_pkg::SQ_W-1:0]    radicand,
  input  scc_pkg::carry_t             in_carry,
  output logic                        out_valid,
  output logic [scc_pkg::LEN_W-1:0]   root,
  output scc_pkg::carry_t             out_carry
);
  import scc_pkg::*;

  logic [SQRT_STEPS:0] valid;
  logic [SQ_W-1:0]     rem [SQRT_STEPS+1];
  logic [SQ_W-1:0]     acc [SQRT_STEPS+1];
  carry_t              cr  [SQRT_STEPS+1];

  assign valid[0] = in_valid;
  assign rem[0]   = radicand;
  assign acc[0]   = '0;
  assign cr[0]    = in_carry;

  // one result bit per stage, msb first
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int              BIT_POS = 2 * (SQRT_STEPS - 1 - j);
    localparam logic [SQ_W-1:0] BIT     = SQ_W'(1) << BIT_POS;
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = acc[j] + BIT;
    assign take  = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= take ? (rem[j] - trial) : rem[j];
      acc[j+1] <= take ? ((acc[j] >> 1) + BIT) : (acc[j] >> 1);
      cr[j+1]  <= cr[j];
    end
  end

  assign out_valid = valid[SQRT_STEPS];
  assign root      = acc[SQRT_STEPS][LEN_W-1:0];
  assign out_carry = cr[SQRT_STEPS];

endmodule

// ===== rtl/scc_div.sv =====
module scc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [scc_pkg::LEN_W-1:0]   len,
  input  scc_pkg::carry_t             in_carry,
  output logic                        out_valid,
  output logic [scc_pkg::LEN_W-1:0]   out_len,
  output logic [scc_pkg::QUO_W-1:0]   quo_a,
  output logic [scc_pkg::QUO_W-1:0]   quo_b,
  output scc_pkg::side_t              out_side
);
  import scc_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } lane_t;

  logic [QUO_W:0]   valid;
  logic [LEN_W-1:0] dlen [QUO_W+1];
  logic             zero [QUO_W+1];
  side_t            side [QUO_W+1];
  lane_t            la   [QUO_W+1];
  lane_t            lb   [QUO_W+1];

  // pre-stage: rounded numerators and overflow check
  logic [NUM_W-1:0] num_a, num_b, den_top;

  always_comb begin
    num_a   = {in_carry.mag_a, NORM_FRAC'(0)} + NUM_W'(len >> 1);
    num_b   = {in_carry.mag_b, NORM_FRAC'(0)} + NUM_W'(len >> 1);
    den_top = {len, QUO_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dlen[0]   <= len;
    zero[0]   <= len == '0;
    side[0]   <= in_carry.side;
    la[0].rem <= num_a;
    la[0].quo <= '0;
    la[0].sat <= num_a >= den_top;
    lb[0].rem <= num_b;
    lb[0].quo <= '0;
    lb[0].sat <= num_b >= den_top;
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int BIT_POS = QUO_W - 1 - j;
    logic [NUM_W-1:0] dsh;
    lane_t            na, nb;

    always_comb begin
      dsh = NUM_W'(dlen[j]) << BIT_POS;
      na  = la[j];
      nb  = lb[j];
      if (la[j].rem >= dsh) begin
        na.rem          = la[j].rem - dsh;
        na.quo[BIT_POS] = 1'b1;
      end
      if (lb[j].rem >= dsh) begin
        nb.rem          = lb[j].rem - dsh;
        nb.quo[BIT_POS] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      dlen[j+1] <= dlen[j];
      zero[j+1] <= zero[j];
      side[j+1] <= side[j];
      la[j+1]   <= na;
      lb[j+1]   <= nb;
    end
  end

  always_comb begin
    if (zero[QUO_W]) begin
      quo_a = '0;
      quo_b = '0;
    end else begin
      quo_a = (la[QUO_W].sat || la[QUO_W].quo > QUO_W'(NORM_ONE)) ?
              QUO_W'(NORM_ONE) : la[QUO_W].quo;
      quo_b = (lb[QUO_W].sat || lb[QUO_W].quo > QUO_W'(NORM_ONE)) ?
              QUO_W'(NORM_ONE) : lb[QUO_W].quo;
    end
  end

  assign out_valid = valid[QUO_W];
  assign out_len   = dlen[QUO_W];
  assign out_side  = side[QUO_W];

endmodule

// ===== rtl/shape_pair_contact_test_core.sv =====
// pipeline: a request accepted with start passes 3 front stages, 32 square root
// stages, 1 + 15 divider stages and 1 output register before the result is taken.
// throughput: one request per cycle, busy stays low; the square root and
// the normal divider are fully pipelined, one bit per stage.
// reset: synchronous rst clears every valid bit, no result is pending after it.
// done is a one-cycle strobe; the receiver cannot stall the pipeline.
`include "shape_pair_contact_test_core_defines.svh"
module shape_pair_contact_test_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  scc_pkg::request_t  request,
  output logic               done,
  output scc_pkg::result_t   result
);
  import scc_pkg::*;

  localparam int LATENCY = 3 + SQRT_STEPS + 1 + QUO_W + 1;

  logic             fr_valid, sq_valid, dv_valid;
  logic [SQ_W-1:0]  fr_sum;
  carry_t           fr_carry, sq_carry;
  logic [LEN_W-1:0] sq_root, dv_len;
  logic [QUO_W-1:0] dv_qa, dv_qb;
  side_t            dv_side;

  assign busy = 1'b0;

  scc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .req       (request),
    .out_valid (fr_valid),
    .sq_sum    (fr_sum),
    .carry     (fr_carry)
  );

  scc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .radicand  (fr_sum),
    .in_carry  (fr_carry),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_carry (sq_carry)
  );

  scc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .len       (sq_root),
    .in_carry  (sq_carry),
    .out_valid (dv_valid),
    .out_len   (dv_len),
    .quo_a     (dv_qa),
    .quo_b     (dv_qb),
    .out_side  (dv_side)
  );

  logic signed [32:0]       pen_full, pen_adj;
  logic signed [31:0]       pen_sat;
  logic signed [NORM_W-1:0] nx, ny;
  result_t                  result_next;

  always_comb begin
    pen_full = $signed({1'b0, dv_side.k}) - $signed({1'b0, dv_len});
    pen_adj  = dv_side.halve ? (pen_full >>> 1) : pen_full;
    // saturate when the top two bits disagree
    if (pen_adj[32] != pen_adj[31]) begin
      pen_sat = pen_adj[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pen_sat = pen_adj[31:0];
    end
    nx = dv_side.neg_a ? (~{1'b0, dv_qa} + 16'd1) : {1'b0, dv_qa};
    ny = dv_side.neg_b ? (~{1'b0, dv_qb} + 16'd1) : {1'b0, dv_qb};

    result_next = '0;
    if (dv_side.hit) begin
      result_next.hit = 1'b1;
      if (dv_side.fixed) begin
        result_next.normal_x    = dv_side.fix_nx;
        result_next.normal_y    = dv_side.fix_ny;
        result_next.penetration = dv_side.fix_pen;
      end else begin
        result_next.normal_x    = nx;
        result_next.normal_y    = ny;
        result_next.penetration = pen_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  `SCC_ASSERT_DLY(a_latency, start && !busy, LATENCY, done)
  `SCC_ASSERT_IMP(a_no_orphan, done, $past(start && !busy, LATENCY))
  `SCC_ASSERT_IMP(a_miss_zero, done && !result.hit,
                  (result.normal_x == 0) && (result.normal_y == 0) && (result.penetration == 0))
  `SCC_ASSERT_IMP(a_unit_range, done,
                  (result.normal_x <= NORM_ONE) && (result.normal_x >= -NORM_ONE) &&
                  (result.normal_y <= NORM_ONE) && (result.normal_y >= -NORM_ONE))

endmodule
